/* src/qsau_pkg.sv */
package qsau_pkg;

  localparam int QW        = 32;
  localparam int PW        = 64;
  localparam int MAG_W     = 63;
  localparam int U_W       = 31;
  localparam int SQ_W      = 62;
  localparam int SUM_W     = 64;
  localparam int ROOT_W    = 32;
  localparam int SREM_W    = 34;
  localparam int DEN_W     = 33;
  localparam int NUM_W     = 63;
  localparam int DREM_W    = 34;
  localparam int SQ_STEPS  = 32;
  localparam int DIV_STEPS = 31;
  localparam int LANES     = 4;
  localparam int NPROD     = 12;

  localparam logic [U_W-1:0] Q_ONE = U_W'(1 << 30);

  typedef logic signed [QW-1:0] word_t;
  typedef logic signed [PW-1:0] prod_t;

endpackage

/* src/quaternion_small_angle_update.sv */
// Channel  Direction  Handshake             Payload
// in       input      in_valid / in_stall   quat_x..quat_w, rot_x..rot_z
// out      output     out_valid / out_stall new_x..new_w, zero_norm
//
// One transaction enters per cycle unless out_stall holds a waiting result; the
// pipeline includes the 32-stage square root and the 31-stage dividers of the four lanes.
// Reset (rst, synchronous) clears every stage valid bit.
// The whole pipeline holds while a result waits on out_stall, so in_stall
// follows the output side in the same cycle and nothing is lost or repeated.
module quaternion_small_angle_update
  import qsau_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] quat_x,
  input  logic [31:0] quat_y,
  input  logic [31:0] quat_z,
  input  logic [31:0] quat_w,
  input  logic [31:0] rot_x,
  input  logic [31:0] rot_y,
  input  logic [31:0] rot_z,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] new_x,
  output logic [31:0] new_y,
  output logic [31:0] new_z,
  output logic [31:0] new_w,
  output logic        zero_norm
);

  logic adv;

  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // Stage 1: products.
  logic             vld1;
  prod_t            prod [NPROD];
  word_t            qreg [LANES];
  word_t            qx_i, qy_i, qz_i, qw_i, px_i, py_i, pz_i;

  assign qx_i = word_t'(quat_x);
  assign qy_i = word_t'(quat_y);
  assign qz_i = word_t'(quat_z);
  assign qw_i = word_t'(quat_w);
  assign px_i = word_t'(rot_x);
  assign py_i = word_t'(rot_y);
  assign pz_i = word_t'(rot_z);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
    end else if (adv) begin
      vld1 <= in_valid;
    end
    if (adv) begin
      prod[0]  <= qw_i * px_i;
      prod[1]  <= qy_i * pz_i;
      prod[2]  <= qz_i * py_i;
      prod[3]  <= qw_i * py_i;
      prod[4]  <= qz_i * px_i;
      prod[5]  <= qx_i * pz_i;
      prod[6]  <= qw_i * pz_i;
      prod[7]  <= qx_i * py_i;
      prod[8]  <= qy_i * px_i;
      prod[9]  <= qx_i * px_i;
      prod[10] <= qy_i * py_i;
      prod[11] <= qz_i * pz_i;
      qreg[0]  <= qx_i;
      qreg[1]  <= qy_i;
      qreg[2]  <= qz_i;
      qreg[3]  <= qw_i;
    end
  end

  // Stage 2: sums of four terms, divided by four with floor.
  logic                    vld2;
  logic signed [PW-1:0]    vsum [LANES];
  logic signed [PW+1:0]    ext [NPROD];
  logic signed [PW+1:0]    qsh [LANES];
  logic signed [PW+1:0]    psum [LANES];

  always_comb begin
    for (int i = 0; i < NPROD; i++) begin
      ext[i] = {{2{prod[i][PW-1]}}, prod[i]};
    end
    for (int i = 0; i < LANES; i++) begin
      qsh[i] = {{4{qreg[i][QW-1]}}, qreg[i], 30'b0};
    end
    psum[0] = ext[0] + qsh[0] + ext[1] - ext[2];
    psum[1] = ext[3] + qsh[1] + ext[4] - ext[5];
    psum[2] = ext[6] + qsh[2] + ext[7] - ext[8];
    psum[3] = qsh[3] - ext[9] - ext[10] - ext[11];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld2 <= 1'b0;
    end else if (adv) begin
      vld2 <= vld1;
    end
    if (adv) begin
      for (int i = 0; i < LANES; i++) begin
        vsum[i] <= psum[i][PW+1:2];
      end
    end
  end

  // Stage 3: magnitudes and signs.
  logic             vld3;
  logic [MAG_W-1:0] mag3 [LANES];
  logic [LANES-1:0] neg3;
  logic [MAG_W-1:0] orw3;
  logic [PW-1:0]    absv [LANES];

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      absv[i] = vsum[i][PW-1] ? PW'(-vsum[i]) : PW'(vsum[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld3 <= 1'b0;
    end else if (adv) begin
      vld3 <= vld2;
    end
    if (adv) begin
      for (int i = 0; i < LANES; i++) begin
        mag3[i] <= absv[i][MAG_W-1:0];
        neg3[i] <= vsum[i][PW-1];
      end
      orw3 <= absv[0][MAG_W-1:0] | absv[1][MAG_W-1:0] |
              absv[2][MAG_W-1:0] | absv[3][MAG_W-1:0];
    end
  end

  // Stage 4: highest nonzero byte of the combined magnitude.
  logic             vld4;
  logic [MAG_W-1:0] mag4 [LANES];
  logic [LANES-1:0] neg4;
  logic             zero4;
  logic [2:0]       grp4;
  logic [7:0]       byte4;
  logic [PW-1:0]    orpad;
  logic [2:0]       grp_c;

  always_comb begin
    orpad = {1'b0, orw3};
    grp_c = 3'd0;
    for (int g = 0; g < 8; g++) begin
      if (orpad[g*8 +: 8] != 8'd0) begin
        grp_c = 3'(g);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld4 <= 1'b0;
    end else if (adv) begin
      vld4 <= vld3;
    end
    if (adv) begin
      mag4  <= mag3;
      neg4  <= neg3;
      zero4 <= (orw3 == '0);
      grp4  <= grp_c;
      byte4 <= orpad[grp_c*8 +: 8];
    end
  end

  // Stage 5: bit length.
  logic             vld5;
  logic [MAG_W-1:0] mag5 [LANES];
  logic [LANES-1:0] neg5;
  logic             zero5;
  logic [6:0]       bl5;
  logic [2:0]       pos_c;

  always_comb begin
    pos_c = 3'd0;
    for (int b = 0; b < 8; b++) begin
      if (byte4[b]) begin
        pos_c = 3'(b);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld5 <= 1'b0;
    end else if (adv) begin
      vld5 <= vld4;
    end
    if (adv) begin
      mag5  <= mag4;
      neg5  <= neg4;
      zero5 <= zero4;
      bl5   <= {1'b0, grp4, pos_c} + 7'd1;
    end
  end

  // Stage 6: block normalization to [2^30, 2^31).
  logic             vld6;
  logic [U_W-1:0]   u6 [LANES];
  logic [LANES-1:0] neg6;
  logic             zero6;
  logic [MAG_W-1:0] shf [LANES];
  logic [6:0]       rsh, lsh;

  always_comb begin
    rsh = bl5 - 7'd31;
    lsh = 7'd31 - bl5;
    for (int i = 0; i < LANES; i++) begin
      shf[i] = (bl5 > 7'd31) ? (mag5[i] >> rsh) : (mag5[i] << lsh);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld6 <= 1'b0;
    end else if (adv) begin
      vld6 <= vld5;
    end
    if (adv) begin
      for (int i = 0; i < LANES; i++) begin
        u6[i] <= shf[i][U_W-1:0];
      end
      neg6  <= neg5;
      zero6 <= zero5;
    end
  end

  // Stage 7: squares.
  logic             vld7;
  logic [U_W-1:0]   u7 [LANES];
  logic [SQ_W-1:0]  sq7 [LANES];
  logic [LANES-1:0] neg7;
  logic             zero7;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld7 <= 1'b0;
    end else if (adv) begin
      vld7 <= vld6;
    end
    if (adv) begin
      for (int i = 0; i < LANES; i++) begin
        sq7[i] <= u6[i] * u6[i];
      end
      u7    <= u6;
      neg7  <= neg6;
      zero7 <= zero6;
    end
  end

  // Square root pipeline, index 0 holds the sum of squares.
  logic [SQ_STEPS:0]              sv;
  logic [SUM_W-1:0]               ss    [SQ_STEPS+1];
  logic [SREM_W-1:0]              srem  [SQ_STEPS+1];
  logic [ROOT_W-1:0]              sroot [SQ_STEPS+1];
  logic [LANES-1:0][U_W-1:0]      su    [SQ_STEPS+1];
  logic [LANES-1:0]               sneg  [SQ_STEPS+1];
  logic [SQ_STEPS:0]              szero;

  always_ff @(posedge clk) begin
    if (rst) begin
      sv[0] <= 1'b0;
    end else if (adv) begin
      sv[0] <= vld7;
    end
    if (adv) begin
      ss[0]    <= SUM_W'(sq7[0]) + SUM_W'(sq7[1]) + SUM_W'(sq7[2]) + SUM_W'(sq7[3]);
      srem[0]  <= '0;
      sroot[0] <= '0;
      for (int i = 0; i < LANES; i++) begin
        su[0][i] <= u7[i];
      end
      sneg[0]  <= neg7;
      szero[0] <= zero7;
    end
  end

  for (genvar k = 1; k <= SQ_STEPS; k++) begin : g_sqrt
    logic [SREM_W-1:0] rsh_c;
    logic [SREM_W-1:0] trial;
    logic              take;

    assign rsh_c = {srem[k-1][SREM_W-3:0], ss[k-1][SUM_W-2*k+1 -: 2]};
    assign trial = {sroot[k-1], 2'b01};
    assign take  = (rsh_c >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        sv[k] <= 1'b0;
      end else if (adv) begin
        sv[k] <= sv[k-1];
      end
      if (adv) begin
        srem[k]  <= take ? (rsh_c - trial) : rsh_c;
        sroot[k] <= {sroot[k-1][ROOT_W-2:0], take};
        ss[k]    <= ss[k-1];
        su[k]    <= su[k-1];
        sneg[k]  <= sneg[k-1];
        szero[k] <= szero[k-1];
      end
    end
  end

  // Divider pipeline, index 0 holds the initial partial remainder.
  logic [DIV_STEPS:0]             dv;
  logic [DEN_W-1:0]               dden  [DIV_STEPS+1];
  logic [LANES-1:0][DREM_W-1:0]   drem  [DIV_STEPS+1];
  logic [LANES-1:0][U_W-1:0]      dlow  [DIV_STEPS+1];
  logic [LANES-1:0][U_W-1:0]      dquot [DIV_STEPS+1];
  logic [LANES-1:0]               dneg  [DIV_STEPS+1];
  logic [DIV_STEPS:0]             dzero;
  logic [NUM_W-1:0]               num0  [LANES];

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      num0[i] = {1'b0, su[SQ_STEPS][i], 31'b0} + NUM_W'(sroot[SQ_STEPS]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else if (adv) begin
      dv[0] <= sv[SQ_STEPS];
    end
    if (adv) begin
      dden[0] <= {sroot[SQ_STEPS], 1'b0};
      for (int i = 0; i < LANES; i++) begin
        drem[0][i]  <= {2'b0, num0[i][NUM_W-1:U_W]};
        dlow[0][i]  <= num0[i][U_W-1:0];
        dquot[0][i] <= '0;
      end
      dneg[0]  <= sneg[SQ_STEPS];
      dzero[0] <= szero[SQ_STEPS];
    end
  end

  for (genvar j = 1; j <= DIV_STEPS; j++) begin : g_div
    logic [LANES-1:0][DREM_W-1:0] sh_c;
    logic [LANES-1:0]             take;

    always_comb begin
      for (int i = 0; i < LANES; i++) begin
        sh_c[i] = {drem[j-1][i][DREM_W-2:0], dlow[j-1][i][DIV_STEPS-j]};
        take[i] = (sh_c[i] >= {1'b0, dden[j-1]});
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[j] <= 1'b0;
      end else if (adv) begin
        dv[j] <= dv[j-1];
      end
      if (adv) begin
        for (int i = 0; i < LANES; i++) begin
          drem[j][i]  <= take[i] ? (sh_c[i] - {1'b0, dden[j-1]}) : sh_c[i];
          dquot[j][i] <= {dquot[j-1][i][U_W-2:0], take[i]};
        end
        dden[j]  <= dden[j-1];
        dlow[j]  <= dlow[j-1];
        dneg[j]  <= dneg[j-1];
        dzero[j] <= dzero[j-1];
      end
    end
  end

  // Output stage: clamp, sign and zero case.
  logic [QW-1:0] res_c [LANES];
  logic [U_W-1:0] qc;

  always_comb begin
    qc = '0;
    for (int i = 0; i < LANES; i++) begin
      qc = (dquot[DIV_STEPS][i] > Q_ONE) ? Q_ONE : dquot[DIV_STEPS][i];
      if (dzero[DIV_STEPS]) begin
        res_c[i] = '0;
      end else if (dneg[DIV_STEPS][i]) begin
        res_c[i] = -{1'b0, qc};
      end else begin
        res_c[i] = {1'b0, qc};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= dv[DIV_STEPS];
    end
    if (adv) begin
      new_x     <= res_c[0];
      new_y     <= res_c[1];
      new_z     <= res_c[2];
      new_w     <= res_c[3];
      zero_norm <= dzero[DIV_STEPS];
    end
  end

  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("Input stalled without a held result.");

  a_entry: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> vld1)
    else $error("Accepted transaction did not enter the pipeline.");

  a_zero_out: assert property (@(posedge clk) disable iff (rst)
    (out_valid && zero_norm) |->
      (new_x == '0 && new_y == '0 && new_z == '0 && new_w == '0))
    else $error("Zero-norm result carries nonzero components.");

  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ($signed(new_x) <= 32'sd1073741824 && $signed(new_x) >= -32'sd1073741824 &&
                   $signed(new_w) <= 32'sd1073741824 && $signed(new_w) >= -32'sd1073741824))
    else $error("Result component out of unit range.");

  a_nonzero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !zero_norm) |->
      (new_x != '0 || new_y != '0 || new_z != '0 || new_w != '0))
    else $error("Nonzero product normalized to all zeros.");

endmodule

/* sim/tb_top.sv */
module tb_top;
  import qsau_pkg::*;

  typedef struct packed {
    logic [31:0] qx, qy, qz, qw, rx, ry, rz;
  } update_t;

  typedef struct packed {
    logic [31:0] x, y, z, w;
    logic        zn;
  } unit_quat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] quat_x = '0, quat_y = '0, quat_z = '0, quat_w = '0;
  logic [31:0] rot_x = '0, rot_y = '0, rot_z = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] new_x, new_y, new_z, new_w;
  logic        zero_norm;

  update_t    pending_updates[$];
  unit_quat_t expected_quats[$];
  int         errors = 0;
  int         accepted = 0;
  int         received = 0;
  int         zero_seen = 0;
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;
  bit         hold_off = 1'b0;

  quaternion_small_angle_update dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #50000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic logic [127:0] quarter_of_sum(logic signed [127:0] a, logic signed [127:0] b,
                                                  logic signed [127:0] c, logic signed [127:0] d);
    logic signed [127:0] s;
    s = a + b + c + d;
    return s >>> 2;
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] s);
    logic [63:0] root;
    logic [63:0] bit_w;
    logic [63:0] rem;
    root = 0;
    rem = s;
    bit_w = 64'd1 << 62;
    while (bit_w > rem) bit_w = bit_w >> 2;
    while (bit_w != 0) begin
      if (rem >= root + bit_w) begin
        rem = rem - (root + bit_w);
        root = (root >> 1) + bit_w;
      end else begin
        root = root >> 1;
      end
      bit_w = bit_w >> 2;
    end
    return root;
  endfunction

  function automatic unit_quat_t normalized_product(update_t u);
    logic signed [127:0] qx, qy, qz, qw, px, py, pz, pw;
    logic signed [127:0] v[4];
    logic [127:0] mag[4];
    logic neg[4];
    logic [127:0] m, s, r, q;
    int bl;
    unit_quat_t res;
    qx = $signed(u.qx); qy = $signed(u.qy); qz = $signed(u.qz); qw = $signed(u.qw);
    px = $signed(u.rx); py = $signed(u.ry); pz = $signed(u.rz); pw = 128'sd1073741824;
    v[0] = quarter_of_sum(qw * px, qx * pw, qy * pz, -(qz * py));
    v[1] = quarter_of_sum(qw * py, qy * pw, qz * px, -(qx * pz));
    v[2] = quarter_of_sum(qw * pz, qz * pw, qx * py, -(qy * px));
    v[3] = quarter_of_sum(qw * pw, -(qx * px), -(qy * py), -(qz * pz));
    m = 0;
    for (int i = 0; i < 4; i++) begin
      neg[i] = v[i] < 0;
      mag[i] = neg[i] ? -v[i] : v[i];
      if (mag[i] > m) m = mag[i];
    end
    res = '0;
    if (m == 0) begin
      res.zn = 1'b1;
      return res;
    end
    bl = 0;
    while (m != 0) begin
      bl++;
      m = m >> 1;
    end
    s = 0;
    for (int i = 0; i < 4; i++) begin
      if (bl > 31) mag[i] = mag[i] >> (bl - 31);
      else mag[i] = mag[i] << (31 - bl);
      s = s + mag[i] * mag[i];
    end
    r = int_sqrt(s[63:0]);
    for (int i = 0; i < 4; i++) begin
      q = ((mag[i] << 31) + r) / (2 * r);
      if (q > 128'd1073741824) q = 128'd1073741824;
      if (neg[i]) q = -q;
      case (i)
        0: res.x = q[31:0];
        1: res.y = q[31:0];
        2: res.z = q[31:0];
        default: res.w = q[31:0];
      endcase
    end
    return res;
  endfunction

  function automatic logic [31:0] rand_word(int mode);
    case (mode)
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 2147483647)) % 1073741825);
      2: return -32'($urandom_range(0, 1073741824));
      3: return 32'($urandom_range(0, 4096)) - 32'd2048;
      default: return {$urandom_range(0, 1) ? 2'b11 : 2'b00, 30'($urandom)};
    endcase
  endfunction

  task automatic queue_update(logic [31:0] qx, qy, qz, qw, rx, ry, rz);
    update_t u;
    u = '{qx, qy, qz, qw, rx, ry, rz};
    pending_updates.push_back(u);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_quats.push_back(normalized_product({quat_x, quat_y, quat_z, quat_w,
                                                     rot_x, rot_y, rot_z}));
        accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_updates.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          update_t u;
          u = pending_updates.pop_front();
          in_valid <= 1'b1;
          {quat_x, quat_y, quat_z, quat_w, rot_x, rot_y, rot_z} <= u;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      unit_quat_t e;
      received++;
      if (expected_quats.size() == 0) begin
        $error("result with no transaction pending");
        errors++;
      end else begin
        e = expected_quats.pop_front();
        if (new_x !== e.x) begin $error("new_x exp %h got %h", e.x, new_x); errors++; end
        if (new_y !== e.y) begin $error("new_y exp %h got %h", e.y, new_y); errors++; end
        if (new_z !== e.z) begin $error("new_z exp %h got %h", e.z, new_z); errors++; end
        if (new_w !== e.w) begin $error("new_w exp %h got %h", e.w, new_w); errors++; end
        if (zero_norm !== e.zn) begin
          $error("zero_norm exp %b got %b", e.zn, zero_norm);
          errors++;
        end
        if (e.zn) zero_seen++;
      end
    end
    out_stall <= hold_off || ($urandom_range(0, 99) < recv_stall_pct);
  end

  task automatic drain();
    while (pending_updates.size() > 0 || in_valid || expected_quats.size() > 0)
      @(posedge clk);
  endtask

  initial begin
    int mode;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    queue_update(0, 0, 0, 0, 0, 0, 0);
    queue_update(0, 0, 0, 32'h4000_0000, 0, 0, 0);
    queue_update(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    queue_update(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    queue_update(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
    queue_update(0, 0, 0, 1, 0, 0, 0);
    queue_update(0, 0, 0, 32'hffff_ffff, 0, 0, 0);
    queue_update(1, 0, 0, 0, 0, 0, 0);
    queue_update(0, 0, 0, 32'h4000_0000, 32'h7fff_ffff, 1, 0);
    queue_update(0, 0, 0, 32'hc000_0000, 0, 0, 32'h8000_0000);
    queue_update(32'h4000_0000, 0, 0, 0, 32'h4000_0000, 0, 0);
    queue_update(32'h4000_0000, 32'h4000_0000, 32'h4000_0000, 32'h4000_0000, 1, 2, 3);
    queue_update(32'h0000_0001, 0, 0, 32'h4000_0000, 0, 0, 0);
    queue_update(32'h2d41_3ccd, 0, 0, 32'h2d41_3ccd, 32'h0010_0000, 32'hfff0_0000, 0);
    queue_update(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    for (int p = 0; p < 5; p++) begin
      case (p)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
        3: begin send_idle_pct = 16; recv_stall_pct = 16; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      for (int k = 0; k < 400; k++) begin
        mode = $urandom_range(0, 4);
        queue_update(rand_word(mode), rand_word(mode), rand_word(mode), rand_word(mode),
                     rand_word($urandom_range(0, 4)), rand_word($urandom_range(0, 4)),
                     rand_word($urandom_range(0, 4)));
      end
      if (p == 4) begin
        hold_off = 1'b1;
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
      end
      drain();
    end
    repeat (100) @(posedge clk);
    $display("Sent %0d quaternion updates and checked %0d results (%0d zero-norm).",
             accepted, received, zero_seen);
    $display("Phases covered free flow, sparse input, heavy output stall and a long hold-off.");
    if (errors == 0 && expected_quats.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
